// ===== design/sbbht_pkg.sv =====
package sbbht_pkg;

    localparam int COORD_WIDTH_DEF    = 32;
    localparam int TIME_FRAC_BITS_DEF = 16;

    // controller -> datapath
    typedef struct packed {
        logic load;        // capture the input transaction
        logic set_reject;  // axis rejects on its own
        logic div_start;   // launch a division
        logic div_exit;    // launched division is the exit candidate
        logic check;       // compare entry against exit
        logic emit;        // load the result register and clear the query
    } sbbht_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic eval_reject;
        logic need_entry;
        logic need_exit;
        logic rejected;
        logic last;
        logic div_done;
        logic out_free;
    } sbbht_stat_t;

endpackage

// ===== design/swept_box_box_hit_time.sv =====
// Swept box test: box A moves by a displacement over one time step against a
// still box B. Each input transaction carries one axis (both intervals and
// A's displacement, signed Q16.16); tlast marks the final axis of a query, and
// only that axis produces a result transaction: hit, and the first contact
// time as an unsigned Q1.16 fraction of the step (65536 is 1.0, 0 on a miss or
// an initial overlap). The block is ready for a new axis only once the last
// one has run the entry and exit divisions that it needs, if any, and the
// final axis of a query has loaded the result register. Its pace is set by
// the single shared restoring divider, which resolves one quotient bit per
// cycle and serves the entry and exit quotients in turn. A result waiting in
// the output register holds the block only once the next query's final axis
// is ready to load its result.
module swept_box_box_hit_time #(
    parameter int COORD_WIDTH    = sbbht_pkg::COORD_WIDTH_DEF,
    parameter int TIME_FRAC_BITS = sbbht_pkg::TIME_FRAC_BITS_DEF,
    parameter int S_TDATA_W      = ((5 * COORD_WIDTH + 7) / 8) * 8,
    parameter int M_TDATA_W      = ((TIME_FRAC_BITS + 2 + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // a_lo, a_hi, b_lo, b_hi, move
    input  logic                 s_tlast,   // last_axis
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // hit, t_enter
);
    import sbbht_pkg::*;

    localparam int CW = COORD_WIDTH;

    sbbht_cmd_t  cmd;
    sbbht_stat_t stat;

    logic signed [CW-1:0]     a_lo, a_hi, b_lo, b_hi, move;
    logic                     hit;
    logic [TIME_FRAC_BITS:0]  t_enter;

    assign a_lo = s_tdata[0*CW +: CW];
    assign a_hi = s_tdata[1*CW +: CW];
    assign b_lo = s_tdata[2*CW +: CW];
    assign b_hi = s_tdata[3*CW +: CW];
    assign move = s_tdata[4*CW +: CW];

    sbbht_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sbbht_dp #(
        .COORD_WIDTH    (COORD_WIDTH),
        .TIME_FRAC_BITS (TIME_FRAC_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .a_lo      (a_lo),
        .a_hi      (a_hi),
        .b_lo      (b_lo),
        .b_hi      (b_hi),
        .move      (move),
        .last_axis (s_tlast),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .hit       (hit),
        .t_enter   (t_enter)
    );

    assign m_tdata = M_TDATA_W'({t_enter, hit});

endmodule

// ===== design/sbbht_div.sv =====
module sbbht_div #(
    parameter int NUM_WIDTH = 33,
    parameter int FRAC_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [NUM_WIDTH-1:0] num,
    input  logic [NUM_WIDTH-1:0] den,
    output logic                 done,
    output logic [FRAC_BITS:0]   quo
);
    localparam int CNT_W = $clog2(FRAC_BITS + 1);
    localparam logic [FRAC_BITS:0] TIME_SAT = {1'b1, {(FRAC_BITS-1){1'b0}}, 1'b1};
    localparam logic [CNT_W-1:0]   CNT_LOAD = CNT_W'(FRAC_BITS);
    localparam logic [CNT_W-1:0]   CNT_ONE  = CNT_W'(1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic                 sat_reg, sat_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [NUM_WIDTH-1:0] rem_reg, rem_next;
    logic [NUM_WIDTH-1:0] den_reg, den_next;
    logic [FRAC_BITS:0]   q_reg, q_next;

    logic [NUM_WIDTH:0]   rem_sh;
    logic [NUM_WIDTH:0]   rem_sub;
    logic                 step_ge;
    logic                 init_ge;

    assign rem_sh  = {rem_reg, 1'b0};
    assign rem_sub = rem_sh - {1'b0, den_reg};
    assign step_ge = rem_sh >= {1'b0, den_reg};
    assign init_ge = num >= den;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        sat_next  = sat_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        if (start) begin
            busy_next = 1'b1;
            den_next  = den;
            sat_next  = {1'b0, num} >= {den, 1'b0};
            rem_next  = init_ge ? (num - den) : num;
            q_next    = {{FRAC_BITS{1'b0}}, init_ge};
            cnt_next  = CNT_LOAD;
        end else if (busy_reg) begin
            // one restoring step per cycle
            rem_next = step_ge ? rem_sub[NUM_WIDTH-1:0] : rem_sh[NUM_WIDTH-1:0];
            q_next   = {q_reg[FRAC_BITS-1:0], step_ge};
            cnt_next = cnt_reg - CNT_ONE;
            if (cnt_reg == CNT_ONE) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        sat_reg <= sat_next;
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quo  = (sat_reg || (q_reg > TIME_SAT)) ? TIME_SAT : q_reg;

endmodule

// ===== design/sbbht_ctrl.sv =====
module sbbht_ctrl (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  sbbht_pkg::sbbht_stat_t    stat,
    output sbbht_pkg::sbbht_cmd_t     cmd
);
    import sbbht_pkg::*;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_EVAL    = 3'd1;
    localparam logic [2:0] ST_DIV_ENT = 3'd2;
    localparam logic [2:0] ST_DIV_EXT = 3'd3;
    localparam logic [2:0] ST_CHECK   = 3'd4;
    localparam logic [2:0] ST_EMIT    = 3'd5;

    logic [2:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (stat.rejected) begin
                    state_next = ST_CHECK;
                end else if (stat.eval_reject) begin
                    cmd.set_reject = 1'b1;
                    state_next     = ST_CHECK;
                end else if (stat.need_entry) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV_ENT;
                end else if (stat.need_exit) begin
                    cmd.div_start = 1'b1;
                    cmd.div_exit  = 1'b1;
                    state_next    = ST_DIV_EXT;
                end else begin
                    state_next = ST_CHECK;
                end
            end
            ST_DIV_ENT: begin
                if (stat.div_done) begin
                    if (stat.need_exit) begin
                        cmd.div_start = 1'b1;
                        cmd.div_exit  = 1'b1;
                        state_next    = ST_DIV_EXT;
                    end else begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_DIV_EXT: begin
                if (stat.div_done) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                cmd.check  = 1'b1;
                state_next = stat.last ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                // hold until the result register is free
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/sbbht_dp.sv =====
module sbbht_dp #(
    parameter int COORD_WIDTH    = 32,
    parameter int TIME_FRAC_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic signed [COORD_WIDTH-1:0] a_lo,
    input  logic signed [COORD_WIDTH-1:0] a_hi,
    input  logic signed [COORD_WIDTH-1:0] b_lo,
    input  logic signed [COORD_WIDTH-1:0] b_hi,
    input  logic signed [COORD_WIDTH-1:0] move,
    input  logic                          last_axis,
    input  sbbht_pkg::sbbht_cmd_t         cmd,
    output sbbht_pkg::sbbht_stat_t        stat,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic                          hit,
    output logic [TIME_FRAC_BITS:0]       t_enter
);
    import sbbht_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int F  = TIME_FRAC_BITS;
    localparam int NW = CW + 1;
    localparam logic [F:0] TIME_ONE = {1'b1, {F{1'b0}}};

    logic signed [CW-1:0] alo_reg, ahi_reg, blo_reg, bhi_reg, mv_reg;
    logic                 last_reg;

    logic [F:0] enter_reg, enter_next;
    logic [F:0] exit_reg, exit_next;
    logic       rej_reg, rej_next;
    logic       sel_exit_reg;

    logic       out_valid_reg, out_valid_next;
    logic       hit_reg;
    logic [F:0] t_reg;

    logic signed [NW-1:0] diff_ab;   // a_hi - b_lo
    logic signed [NW-1:0] diff_ba;   // a_lo - b_hi
    logic signed [NW-1:0] num_ent_s, num_ext_s, mv_ext;
    logic [NW-1:0]        num_mag, den_mag;
    logic                 v_zero, v_neg;
    logic                 div_done;
    logic [F:0]           quo;

    assign diff_ab = {ahi_reg[CW-1], ahi_reg} - {blo_reg[CW-1], blo_reg};
    assign diff_ba = {alo_reg[CW-1], alo_reg} - {bhi_reg[CW-1], bhi_reg};
    assign mv_ext  = {mv_reg[CW-1], mv_reg};

    // relative motion of B is -move: negative when move is positive
    assign v_zero = (mv_reg == '0);
    assign v_neg  = (mv_reg > 0);

    assign num_ent_s = v_neg ? diff_ab : diff_ba;
    assign num_ext_s = v_neg ? diff_ba : diff_ab;

    always_comb begin
        logic signed [NW-1:0] sel;
        sel     = cmd.div_exit ? num_ext_s : num_ent_s;
        num_mag = sel[NW-1] ? NW'(-sel) : NW'(sel);
        den_mag = mv_ext[NW-1] ? NW'(-mv_ext) : NW'(mv_ext);
    end

    always_comb begin
        stat.eval_reject = v_zero ? ((ahi_reg < blo_reg) || (alo_reg > bhi_reg))
                                  : (v_neg ? (bhi_reg < alo_reg) : (ahi_reg < blo_reg));
        // a still axis narrows nothing
        stat.need_entry  = !v_zero && (v_neg ? (ahi_reg < blo_reg) : (bhi_reg < alo_reg));
        stat.need_exit   = !v_zero && (v_neg ? (bhi_reg > alo_reg) : (ahi_reg > blo_reg));
        stat.rejected    = rej_reg;
        stat.last        = last_reg;
        stat.div_done    = div_done;
        stat.out_free    = !out_valid_reg || m_tready;
    end

    sbbht_div #(
        .NUM_WIDTH (NW),
        .FRAC_BITS (F)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (num_mag),
        .den     (den_mag),
        .done    (div_done),
        .quo     (quo)
    );

    always_comb begin
        enter_next     = enter_reg;
        exit_next      = exit_reg;
        rej_next       = rej_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (div_done) begin
            if (sel_exit_reg) begin
                if (quo < exit_reg) begin
                    exit_next = quo;
                end
            end else if (quo > enter_reg) begin
                enter_next = quo;
            end
        end
        if (cmd.set_reject) begin
            rej_next = 1'b1;
        end
        if (cmd.check && (enter_reg > exit_reg)) begin
            rej_next = 1'b1;
        end
        if (cmd.emit) begin
            out_valid_next = 1'b1;
            enter_next     = '0;
            exit_next      = TIME_ONE;
            rej_next       = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enter_reg     <= '0;
            exit_reg      <= TIME_ONE;
            rej_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            enter_reg     <= enter_next;
            exit_reg      <= exit_next;
            rej_reg       <= rej_next;
            out_valid_reg <= out_valid_next;
        end
        if (cmd.load) begin
            alo_reg  <= a_lo;
            ahi_reg  <= a_hi;
            blo_reg  <= b_lo;
            bhi_reg  <= b_hi;
            mv_reg   <= move;
            last_reg <= last_axis;
        end
        if (cmd.div_start) begin
            sel_exit_reg <= cmd.div_exit;
        end
        if (cmd.emit) begin
            hit_reg <= !rej_reg;
            t_reg   <= rej_reg ? '0 : enter_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign hit      = hit_reg;
    assign t_enter  = t_reg;

endmodule

// ===== design/sbbht_checker.sv =====
module sbbht_checker #(
    parameter int TIME_FRAC_BITS = sbbht_pkg::TIME_FRAC_BITS_DEF,
    parameter int M_TDATA_W      = 24
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 s_tlast,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);
    localparam int F = TIME_FRAC_BITS;
    localparam logic [F:0] TIME_ONE = {1'b1, {F{1'b0}}};

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a miss carries a zero time
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[F+1:1] == '0)
        else $error("miss with nonzero time");

    // a hit never lies beyond the step
    a_hit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[F+1:1] <= TIME_ONE)
        else $error("contact time beyond 1.0");

    // one axis at a time
    a_one_axis: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second axis taken while busy");

    // a non-final axis produces no result on the following cycle
    a_no_early: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tlast && !m_tvalid |=> !m_tvalid)
        else $error("result raised for a non-final axis");

endmodule

bind swept_box_box_hit_time sbbht_checker #(
    .TIME_FRAC_BITS (TIME_FRAC_BITS),
    .M_TDATA_W      (M_TDATA_W)
) u_sbbht_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/sv/swept_box_box_hit_time_tb.sv =====
`timescale 1ns / 100ps

module swept_box_box_hit_time_tb;
    import sbbht_pkg::*;

    localparam int CW             = COORD_WIDTH_DEF;
    localparam int TFB            = TIME_FRAC_BITS_DEF;
    localparam int S_W            = ((5 * CW + 7) / 8) * 8;
    localparam int M_W            = ((TFB + 2 + 7) / 8) * 8;
    localparam int ONE            = 1 << 16;  // 1.0 in Q16.16
    localparam int CMIN           = int'(32'h8000_0000);
    localparam int CMAX           = int'(32'h7fff_ffff);
    localparam int SPAN           = 1 << 19;
    localparam logic [TFB:0] TIME_ONE = {1'b1, {TFB{1'b0}}};
    localparam logic [TFB:0] TIME_SAT = {1'b1, {(TFB-1){1'b0}}, 1'b1};
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 60;

    typedef struct {
        int a_lo;
        int a_hi;
        int b_lo;
        int b_hi;
        int mv;
        bit last;
    } axis_t;

    typedef struct {
        bit           hit;
        logic [TFB:0] t_enter;
    } contact_t;

    logic           aclk     = 1'b0;
    logic           aresetn  = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [S_W-1:0] s_tdata  = '0;   // a_lo, a_hi, b_lo, b_hi, move
    logic           s_tlast  = 1'b0; // last_axis
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [M_W-1:0] m_tdata;         // hit, t_enter

    // entry/exit window of the query in flight
    logic [TFB:0] win_enter    = '0;
    logic [TFB:0] win_exit     = TIME_ONE;
    bit           win_rejected = 1'b0;

    contact_t expected_hits[$];
    contact_t exp_contact;
    int       errors        = 0;
    int       axes_sent     = 0;
    int       send_idle_pct = 0;
    int       stall_pct     = 0;
    int       quiet_cycles  = 0;

    swept_box_box_hit_time i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Truncated num/den in Q1.TFB, saturating one LSB above 1.0
    function automatic logic [TFB:0] contact_quotient(input longint unsigned num,
                                                      input longint unsigned den);
        longint unsigned q;
        longint unsigned rem;
        if (num >= den * 2)
            return TIME_SAT;
        q   = (num >= den) ? 1 : 0;
        rem = num - q * den;
        for (int i = 0; i < TFB; i++) begin
            rem = rem << 1;
            q   = q << 1;
            if (rem >= den) begin
                rem = rem - den;
                q   = q | 1;
            end
        end
        if (q > TIME_SAT)
            q = TIME_SAT;
        return q[TFB:0];
    endfunction

    // Narrow the window with one axis; on the last axis queue the contact
    function automatic void predict_axis(input axis_t ax);
        longint          alo;
        longint          ahi;
        longint          blo;
        longint          bhi;
        longint          vel;
        longint unsigned den;
        logic [TFB:0]    t;
        contact_t        res;
        alo = ax.a_lo;
        ahi = ax.a_hi;
        blo = ax.b_lo;
        bhi = ax.b_hi;
        vel = -longint'(ax.mv);
        den = (vel < 0) ? -vel : vel;
        if (!win_rejected) begin
            if (vel == 0) begin
                if (ahi < blo || alo > bhi)
                    win_rejected = 1'b1;
            end else if (vel < 0) begin
                if (bhi < alo) begin
                    win_rejected = 1'b1;
                end else begin
                    if (ahi < blo) begin
                        t = contact_quotient(blo - ahi, den);
                        if (t > win_enter)
                            win_enter = t;
                    end
                    if (bhi > alo) begin
                        t = contact_quotient(bhi - alo, den);
                        if (t < win_exit)
                            win_exit = t;
                    end
                end
            end else begin
                if (ahi < blo) begin
                    win_rejected = 1'b1;
                end else begin
                    if (bhi < alo) begin
                        t = contact_quotient(alo - bhi, den);
                        if (t > win_enter)
                            win_enter = t;
                    end
                    if (ahi > blo) begin
                        t = contact_quotient(ahi - blo, den);
                        if (t < win_exit)
                            win_exit = t;
                    end
                end
            end
            if (!win_rejected && win_enter > win_exit)
                win_rejected = 1'b1;
        end
        if (ax.last) begin
            res.hit     = !win_rejected;
            res.t_enter = win_rejected ? '0 : win_enter;
            expected_hits.push_back(res);
            win_enter    = '0;
            win_exit     = TIME_ONE;
            win_rejected = 1'b0;
        end
    endfunction

    function automatic axis_t axis_item(input int alo, input int ahi, input int blo,
                                        input int bhi, input int mv, input bit last);
        axis_t ax;
        ax.a_lo = alo;
        ax.a_hi = ahi;
        ax.b_lo = blo;
        ax.b_hi = bhi;
        ax.mv   = mv;
        ax.last = last;
        return ax;
    endfunction

    function automatic int corner_coord();
        case ($urandom_range(6))
            0: return 0;
            1: return 1;
            2: return -1;
            3: return CMIN;
            4: return CMAX;
            5: return ONE;
            default: return -ONE;
        endcase
    endfunction

    // Entered and left at a falling edge
    task automatic send_axis(input axis_t ax);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ax.mv, ax.b_hi, ax.b_lo, ax.a_hi, ax.a_lo};
        s_tlast  <= ax.last;
        do @(posedge aclk); while (s_tready !== 1'b1);
        predict_axis(ax);
        axes_sent++;
        @(negedge aclk);
    endtask

    // Hold the sender until every expected result has been taken
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (expected_hits.size() != 0)
            @(negedge aclk);
    endtask

    task automatic test_still_boxes();
        send_axis(axis_item(0, ONE, ONE / 2, 2 * ONE, 0, 1'b1));
        send_axis(axis_item(0, ONE, 2 * ONE, 3 * ONE, 0, 1'b1));
        send_axis(axis_item(0, ONE, ONE, 2 * ONE, 0, 1'b1));
        // inverted bounds are compared as given
        send_axis(axis_item(3 * ONE, ONE, 2 * ONE, 2 * ONE, 0, 1'b1));
        send_axis(axis_item(ONE, 0, 0, ONE, 2 * ONE, 1'b1));
    endtask

    task automatic test_moving_apart();
        send_axis(axis_item(2 * ONE, 3 * ONE, 0, ONE, ONE, 1'b1));
        send_axis(axis_item(0, ONE, 2 * ONE, 3 * ONE, -ONE, 1'b1));
    endtask

    task automatic test_contact_times();
        send_axis(axis_item(0, ONE, 2 * ONE, 3 * ONE, 4 * ONE, 1'b1));
        send_axis(axis_item(0, ONE, 2 * ONE, 3 * ONE, ONE, 1'b1));
        send_axis(axis_item(0, ONE, 2 * ONE, 3 * ONE, ONE - 1, 1'b1));
        send_axis(axis_item(0, ONE, 2 * ONE, 3 * ONE, 1, 1'b1));
    endtask

    task automatic test_extreme_coords();
        send_axis(axis_item(4 * ONE, 5 * ONE, 0, ONE, CMIN, 1'b1));
        send_axis(axis_item(CMIN, CMIN, CMAX, CMAX, CMAX, 1'b1));
        send_axis(axis_item(CMIN, CMAX, 0, 0, CMIN, 1'b1));
        send_axis(axis_item(CMAX, CMAX, CMIN, CMIN, CMIN, 1'b1));
    endtask

    task automatic test_multi_axis();
        // all axes touch
        send_axis(axis_item(0, ONE, 2 * ONE, 3 * ONE, 4 * ONE, 1'b0));
        send_axis(axis_item(0, ONE, ONE / 2, 2 * ONE, 0, 1'b0));
        send_axis(axis_item(5 * ONE, 6 * ONE, 0, 4 * ONE, -8 * ONE, 1'b1));
        // first axis rejects, later ones would hit
        send_axis(axis_item(0, ONE, 2 * ONE, 3 * ONE, 0, 1'b0));
        send_axis(axis_item(0, ONE, 2 * ONE, 3 * ONE, 4 * ONE, 1'b1));
        // entry on the second axis passes exit on the first
        send_axis(axis_item(0, 0, ONE, ONE + ONE / 5, 2 * ONE, 1'b0));
        send_axis(axis_item(0, 0, 91750, 100000, 2 * ONE, 1'b1));
    endtask

    task automatic test_random_queries(input int n_items, input int idle_pct,
                                       input int stall);
        int    target;
        int    n_axes;
        int    sel;
        int    c_a;
        int    c_b;
        int    w_a;
        int    w_b;
        int    tmp;
        axis_t ax;
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        target        = axes_sent + n_items;
        while (axes_sent < target) begin
            n_axes = ($urandom_range(9) < 7) ? 3 : $urandom_range(1, 2);
            for (int k = 0; k < n_axes; k++) begin
                sel = $urandom_range(99);
                if (sel < 80) begin
                    c_a     = int'($urandom_range(2 * SPAN)) - SPAN;
                    c_b     = c_a + int'($urandom_range(SPAN)) - SPAN / 2;
                    w_a     = $urandom_range(2 * ONE);
                    w_b     = $urandom_range(2 * ONE);
                    ax.a_lo = c_a - w_a;
                    ax.a_hi = c_a + w_a;
                    ax.b_lo = c_b - w_b;
                    ax.b_hi = c_b + w_b;
                    ax.mv   = ($urandom_range(9) == 0) ? 0
                              : int'($urandom_range(4 * SPAN)) - 2 * SPAN;
                    if ($urandom_range(19) == 0) begin
                        tmp     = ax.a_lo;
                        ax.a_lo = ax.a_hi;
                        ax.a_hi = tmp;
                    end
                end else if (sel < 90) begin
                    ax.a_lo = $urandom;
                    ax.a_hi = $urandom;
                    ax.b_lo = $urandom;
                    ax.b_hi = $urandom;
                    ax.mv   = $urandom;
                end else begin
                    ax.a_lo = corner_coord();
                    ax.a_hi = corner_coord();
                    ax.b_lo = corner_coord();
                    ax.b_hi = corner_coord();
                    ax.mv   = corner_coord();
                end
                ax.last = (k == n_axes - 1);
                send_axis(ax);
            end
        end
    endtask

    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    always @(posedge aclk) begin
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            if (expected_hits.size() == 0) begin
                $display("%0t: unexpected transaction, expected none, actual hit=%0d t_enter=%0d",
                         $time, m_tdata[0], m_tdata[TFB+1:1]);
                errors++;
            end else begin
                exp_contact = expected_hits.pop_front();
                if (m_tdata[0] !== exp_contact.hit) begin
                    $display("%0t: hit mismatch, expected %0d, actual %0d",
                             $time, exp_contact.hit, m_tdata[0]);
                    errors++;
                end
                if (m_tdata[TFB+1:1] !== exp_contact.t_enter) begin
                    $display("%0t: t_enter mismatch, expected %0d, actual %0d",
                             $time, exp_contact.t_enter, m_tdata[TFB+1:1]);
                    errors++;
                end
                if (m_tdata[M_W-1:TFB+2] !== '0) begin
                    $display("%0t: tdata padding mismatch, expected 0, actual %0h",
                             $time, m_tdata[M_W-1:TFB+2]);
                    errors++;
                end
            end
        end
    end

    // Count cycles with no transaction on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("** swept_box_box_hit_time: FAILED **");
            $finish;
        end
    end

    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        test_still_boxes();
        test_moving_apart();
        test_contact_times();
        test_extreme_coords();
        test_multi_axis();
        test_random_queries(310, 0, 0);
        drain_results();
        test_random_queries(310, 56, 0);
        drain_results();
        test_random_queries(310, 0, 56);
        drain_results();
        test_random_queries(310, 8, 8);
        drain_results();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (expected_hits.size() != 0)
            $display("%0t: %0d expected transactions never arrived",
                     $time, expected_hits.size());
        if (errors == 0 && expected_hits.size() == 0)
            $display("** swept_box_box_hit_time: PASSED **");
        else
            $display("** swept_box_box_hit_time: FAILED **");
        $finish;
    end

endmodule
